// File: rtl/core/assert_macros.svh
// Assertion macros used by rbme_ctrl; clk and rst_n come from the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rbme_pkg.sv
// Shared types and constants of the energy and pre-activation block.
`timescale 1ns / 1ps

package rbme_pkg;

  localparam int VAL_W     = 16;  // Q4.12 parameter width
  localparam int RES_W     = 25;  // result width
  localparam int VEC_W     = 16;  // binary vector width
  localparam int UNIT_W    = 4;   // unit index width on loads and results
  localparam int CNT_W     = 5;   // unit count register width
  localparam int IDX_W     = 5;   // walk counter width (counts never exceed 31)
  localparam int OP_W      = 3;
  localparam int CFG_IDX_W = 2;

  localparam int RES_MAX = 16777215;
  localparam int RES_MIN = -16777216;

  localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN_COUNT  = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_W   = 3'd0,
    OP_LOAD_VB  = 3'd1,
    OP_LOAD_HB  = 3'd2,
    OP_ENERGY   = 3'd3,
    OP_HIDDEN   = 3'd4,
    OP_VISIBLE  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    Q_ENERGY,
    Q_HIDDEN,
    Q_VISIBLE
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_SUM,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             ld_w;
    logic             ld_vb;
    logic             ld_hb;
    logic             start;
    kind_t            kind;
    logic             clr_en;
    logic             rd_en;
    logic             sum_en;
    logic             emit;
    logic             emit_last;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic clr_done;
  } sts_t;

endpackage

// File: rtl/core/rbme_ctrl.sv
// Sequencer: unit count registers, query state machine and datapath commands.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rbme_ctrl #(
  parameter int MAX_VISIBLE = 16,
  parameter int MAX_HIDDEN  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic [rbme_pkg::OP_W-1:0]          in_operation,
  output logic                               in_stall,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rbme_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rbme_pkg::CNT_W-1:0]         cfg_data,
  input  rbme_pkg::sts_t                     sts,
  output rbme_pkg::cmd_t                     cmd
);

  localparam int CNT_W = rbme_pkg::CNT_W;
  localparam int IDX_W = rbme_pkg::IDX_W;

  rbme_pkg::state_t state_r, state_nxt;
  rbme_pkg::kind_t  kind_r, kind_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] vcount_r, hcount_r;
  logic [CNT_W-1:0] nv, nh;
  logic [IDX_W-1:0] nv_last, nh_last, walk_last, emit_last_idx;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= CNT_W'(16);
      hcount_r <= CNT_W'(16);
    end else if (cfg_valid) begin
      case (cfg_index)
        rbme_pkg::CFG_VISIBLE_COUNT: vcount_r <= cfg_data;
        rbme_pkg::CFG_HIDDEN_COUNT:  hcount_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the array size acts as the size
  always_comb begin
    nv = vcount_r;
    if (nv == '0) nv = CNT_W'(1);
    else if (32'(nv) > MAX_VISIBLE) nv = CNT_W'(MAX_VISIBLE);
    nh = hcount_r;
    if (nh == '0) nh = CNT_W'(1);
    else if (32'(nh) > MAX_HIDDEN) nh = CNT_W'(MAX_HIDDEN);
    nv_last = IDX_W'(nv - CNT_W'(1));
    nh_last = IDX_W'(nh - CNT_W'(1));
    walk_last = (kind_r == rbme_pkg::Q_VISIBLE) ? nh_last : nv_last;
    case (kind_r)
      rbme_pkg::Q_HIDDEN:  emit_last_idx = nh_last;
      rbme_pkg::Q_VISIBLE: emit_last_idx = nv_last;
      default:             emit_last_idx = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rbme_pkg::ST_CLEAR;
      kind_r  <= rbme_pkg::Q_ENERGY;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.kind  = kind_r;
    cmd.idx   = cnt_r;
    in_stall  = (state_r != rbme_pkg::ST_IDLE);
    unique case (state_r)
      rbme_pkg::ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_done) state_nxt = rbme_pkg::ST_IDLE;
      end
      rbme_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (in_operation)
            rbme_pkg::OP_LOAD_W:  cmd.ld_w  = 1'b1;
            rbme_pkg::OP_LOAD_VB: cmd.ld_vb = 1'b1;
            rbme_pkg::OP_LOAD_HB: cmd.ld_hb = 1'b1;
            rbme_pkg::OP_ENERGY: begin
              kind_nxt  = rbme_pkg::Q_ENERGY;
              cmd.start = 1'b1;
            end
            rbme_pkg::OP_HIDDEN: begin
              kind_nxt  = rbme_pkg::Q_HIDDEN;
              cmd.start = 1'b1;
            end
            rbme_pkg::OP_VISIBLE: begin
              kind_nxt  = rbme_pkg::Q_VISIBLE;
              cmd.start = 1'b1;
            end
            default: ;
          endcase
          if (cmd.start) begin
            cmd.kind  = kind_nxt;
            cnt_nxt   = '0;
            state_nxt = rbme_pkg::ST_WALK;
          end
        end
      end
      rbme_pkg::ST_WALK: begin
        cmd.rd_en = 1'b1;
        if (cnt_r == walk_last) begin
          cnt_nxt   = '0;
          state_nxt = rbme_pkg::ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      rbme_pkg::ST_DRAIN: begin
        // last row read lands in the lanes at this edge
        cnt_nxt   = '0;
        state_nxt = (kind_r == rbme_pkg::Q_ENERGY) ? rbme_pkg::ST_SUM : rbme_pkg::ST_EMIT;
      end
      rbme_pkg::ST_SUM: begin
        cmd.sum_en = 1'b1;
        if (cnt_r == nh_last) begin
          cnt_nxt   = '0;
          state_nxt = rbme_pkg::ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      rbme_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = (cnt_r == emit_last_idx);
          if (cmd.emit_last) begin
            cnt_nxt   = '0;
            state_nxt = rbme_pkg::ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + IDX_W'(1);
          end
        end
      end
      default: state_nxt = rbme_pkg::ST_IDLE;
    endcase
  end

  `CHK_IMPLY(a_emit_free, cmd.emit, sts.out_free, "result issued into a busy output slot")
  `CHK_NEXT(a_start_walk, cmd.start, state_r == rbme_pkg::ST_WALK && cnt_r == '0, "query start lost")
  `CHK_IMPLY(a_rd_range, cmd.rd_en, cnt_r <= walk_last, "row read beyond the unit count")
  `CHK_NEXT(a_last_idle, cmd.emit && cmd.emit_last, !in_stall, "not ready after final result")

endmodule

// File: rtl/core/rbme_datapath.sv
// Weight and bias stores, accumulation lanes, energy accumulator and output register.
`timescale 1ns / 1ps

module rbme_datapath #(
  parameter int MAX_VISIBLE = 16,
  parameter int MAX_HIDDEN  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rbme_pkg::cmd_t                      cmd,
  output rbme_pkg::sts_t                      sts,
  input  logic [rbme_pkg::UNIT_W-1:0]         in_row_index,
  input  logic [rbme_pkg::UNIT_W-1:0]         in_column_index,
  input  logic signed [rbme_pkg::VAL_W-1:0]   in_load_value,
  input  logic [rbme_pkg::VEC_W-1:0]          in_visible_bits,
  input  logic [rbme_pkg::VEC_W-1:0]          in_hidden_bits,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic signed [rbme_pkg::RES_W-1:0]   out_result_value,
  output logic [rbme_pkg::UNIT_W-1:0]         out_unit_index,
  output logic                                out_last_result
);

  localparam int VAL_W = rbme_pkg::VAL_W;
  localparam int RES_W = rbme_pkg::RES_W;
  localparam int IDX_W = rbme_pkg::IDX_W;
  localparam int VEC_W = rbme_pkg::VEC_W;
  localparam int VA    = (MAX_VISIBLE > 1) ? $clog2(MAX_VISIBLE) : 1;
  localparam int HA    = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
  localparam int CLR_N = (MAX_VISIBLE > MAX_HIDDEN) ? MAX_VISIBLE : MAX_HIDDEN;
  localparam int CLR_W = (CLR_N > 1) ? $clog2(CLR_N) : 1;
  localparam int ACC_W = 17 + $clog2(MAX_VISIBLE * MAX_HIDDEN + MAX_VISIBLE + MAX_HIDDEN);
  localparam int SAT_W = ((ACC_W > RES_W) ? ACC_W : RES_W) + 1;
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(rbme_pkg::RES_MAX);
  localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(rbme_pkg::RES_MIN);

  // W is kept twice: by visible row and by hidden row, so each query reads a row per cycle
  logic signed [VAL_W-1:0] w_mem [MAX_VISIBLE][MAX_HIDDEN];
  logic signed [VAL_W-1:0] t_mem [MAX_HIDDEN][MAX_VISIBLE];
  logic signed [VAL_W-1:0] w_row_r [MAX_HIDDEN];
  logic signed [VAL_W-1:0] t_row_r [MAX_VISIBLE];

  logic signed [VAL_W-1:0] vb_r [MAX_VISIBLE];
  logic signed [VAL_W-1:0] hb_r [MAX_HIDDEN];

  logic signed [ACC_W-1:0] hacc_r [MAX_HIDDEN];
  logic signed [ACC_W-1:0] vacc_r [MAX_VISIBLE];
  logic signed [ACC_W-1:0] scal_r;

  rbme_pkg::kind_t    kind_r;
  logic [VEC_W-1:0]   vbits_r, hbits_r;
  logic               rd_vld_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic [CLR_W-1:0]   clr_cnt_r;

  logic               out_valid_r;
  logic signed [RES_W-1:0] out_value_r;
  logic [rbme_pkg::UNIT_W-1:0] out_unit_r;
  logic               out_last_r;

  logic               row_ok, col_ok, clr_w_ok, clr_t_ok;
  logic [VA-1:0]      ld_row, rd_va, clr_w_addr;
  logic [HA-1:0]      ld_col, clr_t_addr;
  logic [VEC_W-1:0]   rd_bits;
  logic               rd_bit, sum_bit;
  logic signed [ACC_W-1:0] emit_sel;
  logic signed [SAT_W-1:0] emit_ext;
  logic signed [RES_W-1:0] emit_val;

  assign row_ok     = 32'(in_row_index) < MAX_VISIBLE;
  assign col_ok     = 32'(in_column_index) < MAX_HIDDEN;
  assign ld_row     = VA'(in_row_index);
  assign ld_col     = HA'(in_column_index);
  assign clr_w_ok   = 32'(clr_cnt_r) < MAX_VISIBLE;
  assign clr_t_ok   = 32'(clr_cnt_r) < MAX_HIDDEN;
  assign clr_w_addr = VA'(clr_cnt_r);
  assign clr_t_addr = HA'(clr_cnt_r);
  assign rd_va      = VA'(rd_idx_r);

  assign sts.clr_done = (clr_cnt_r == CLR_W'(CLR_N - 1));
  assign sts.out_free = !out_valid_r || !out_stall;

  // clearing pass after reset, then single-entry loads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en && !sts.clr_done) begin
      clr_cnt_r <= clr_cnt_r + CLR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      if (clr_w_ok) begin
        for (int l = 0; l < MAX_HIDDEN; l++) w_mem[clr_w_addr][l] <= '0;
      end
      if (clr_t_ok) begin
        for (int l = 0; l < MAX_VISIBLE; l++) t_mem[clr_t_addr][l] <= '0;
      end
    end else if (cmd.ld_w && row_ok && col_ok) begin
      w_mem[ld_row][ld_col] <= in_load_value;
      t_mem[ld_col][ld_row] <= in_load_value;
    end
    if (cmd.rd_en && cmd.kind != rbme_pkg::Q_VISIBLE) w_row_r <= w_mem[VA'(cmd.idx)];
    if (cmd.rd_en && cmd.kind == rbme_pkg::Q_VISIBLE) t_row_r <= t_mem[HA'(cmd.idx)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_VISIBLE; i++) vb_r[i] <= '0;
      for (int j = 0; j < MAX_HIDDEN; j++) hb_r[j] <= '0;
    end else begin
      if (cmd.ld_vb && row_ok) vb_r[ld_row] <= in_load_value;
      if (cmd.ld_hb && col_ok) hb_r[ld_col] <= in_load_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cmd.idx;
  end

  // row in flight belongs to unit rd_idx_r; the walked vector picks whether it counts
  assign rd_bits = (kind_r == rbme_pkg::Q_VISIBLE) ? hbits_r : vbits_r;
  assign rd_bit  = (rd_idx_r < IDX_W'(VEC_W)) ? rd_bits[rd_idx_r[3:0]] : 1'b0;
  assign sum_bit = (cmd.idx < IDX_W'(VEC_W)) ? hbits_r[cmd.idx[3:0]] : 1'b0;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_r  <= cmd.kind;
      vbits_r <= in_visible_bits;
      hbits_r <= in_hidden_bits;
      scal_r  <= '0;
      for (int j = 0; j < MAX_HIDDEN; j++) hacc_r[j] <= ACC_W'(hb_r[j]);
      for (int i = 0; i < MAX_VISIBLE; i++) vacc_r[i] <= ACC_W'(vb_r[i]);
    end else begin
      if (rd_vld_r && rd_bit) begin
        if (kind_r == rbme_pkg::Q_VISIBLE) begin
          for (int i = 0; i < MAX_VISIBLE; i++) vacc_r[i] <= vacc_r[i] + ACC_W'(t_row_r[i]);
        end else begin
          for (int j = 0; j < MAX_HIDDEN; j++) hacc_r[j] <= hacc_r[j] + ACC_W'(w_row_r[j]);
        end
        // energy picks up a.v during the walk
        if (kind_r == rbme_pkg::Q_ENERGY) scal_r <= scal_r + ACC_W'(vb_r[rd_va]);
      end
      // then h against the finished hidden lanes (b.h + v'Wh)
      if (cmd.sum_en && sum_bit) scal_r <= scal_r + hacc_r[HA'(cmd.idx)];
    end
  end

  always_comb begin
    case (kind_r)
      rbme_pkg::Q_HIDDEN:  emit_sel = hacc_r[HA'(cmd.idx)];
      rbme_pkg::Q_VISIBLE: emit_sel = vacc_r[VA'(cmd.idx)];
      default:             emit_sel = scal_r;
    endcase
    emit_ext = SAT_W'(emit_sel);
    if (kind_r == rbme_pkg::Q_ENERGY) emit_ext = -emit_ext;
    if (emit_ext > SAT_HI) emit_val = RES_W'(SAT_HI);
    else if (emit_ext < SAT_LO) emit_val = RES_W'(SAT_LO);
    else emit_val = RES_W'(emit_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_r <= emit_val;
      out_unit_r  <= cmd.idx[3:0];
      out_last_r  <= cmd.emit_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_unit_index   = out_unit_r;
  assign out_last_result  = out_last_r;

endmodule

// File: rtl/core/rbm_energy_and_preactivation.sv
// Top level of the energy and pre-activation block: sequencer plus datapath.
`timescale 1ns / 1ps

// Holds W (MAX_VISIBLE x MAX_HIDDEN), visible and hidden biases in Q4.12 and answers
// energy and pre-activation queries with 25-bit Q.12 results. A load gives no result.
// A query reads one weight row per cycle from a single read port across all lanes:
// hidden pre-activations walk nv rows and then give nh results, one per cycle while
// the output is not stalled; visible pre-activations walk nh rows and then give nv
// results; the energy walks nv rows, then sums over nh hidden lanes before its single
// result (nv, nh being the clamped unit counts). The next item is taken as soon as the
// final result sits in the output register. After reset the weight stores are cleared
// one row per cycle, during which in_stall stays high; configuration
// writes are taken at any time.
module rbm_energy_and_preactivation #(
  parameter int MAX_VISIBLE = 16,
  parameter int MAX_HIDDEN  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rbme_pkg::OP_W-1:0]           in_operation,
  input  logic [rbme_pkg::UNIT_W-1:0]         in_row_index,
  input  logic [rbme_pkg::UNIT_W-1:0]         in_column_index,
  input  logic signed [rbme_pkg::VAL_W-1:0]   in_load_value,
  input  logic [rbme_pkg::VEC_W-1:0]          in_visible_bits,
  input  logic [rbme_pkg::VEC_W-1:0]          in_hidden_bits,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rbme_pkg::RES_W-1:0]   out_result_value,
  output logic [rbme_pkg::UNIT_W-1:0]         out_unit_index,
  output logic                                out_last_result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rbme_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rbme_pkg::CNT_W-1:0]          cfg_data
);

  rbme_pkg::cmd_t cmd;
  rbme_pkg::sts_t sts;

  rbme_ctrl #(
    .MAX_VISIBLE (MAX_VISIBLE),
    .MAX_HIDDEN  (MAX_HIDDEN)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sts          (sts),
    .cmd          (cmd)
  );

  rbme_datapath #(
    .MAX_VISIBLE (MAX_VISIBLE),
    .MAX_HIDDEN  (MAX_HIDDEN)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_row_index     (in_row_index),
    .in_column_index  (in_column_index),
    .in_load_value    (in_load_value),
    .in_visible_bits  (in_visible_bits),
    .in_hidden_bits   (in_hidden_bits),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_unit_index   (out_unit_index),
    .out_last_result  (out_last_result)
  );

endmodule

// File: test/tb.sv
// Self-checking testbench for the energy and pre-activation block.
`timescale 1ns / 1ps

module tb;

  localparam int OP_W      = rbme_pkg::OP_W;
  localparam int UNIT_W    = rbme_pkg::UNIT_W;
  localparam int VAL_W     = rbme_pkg::VAL_W;
  localparam int VEC_W     = rbme_pkg::VEC_W;
  localparam int RES_W     = rbme_pkg::RES_W;
  localparam int CNT_W     = rbme_pkg::CNT_W;
  localparam int CFG_IDX_W = rbme_pkg::CFG_IDX_W;

  localparam int NUM_VIS = 16;
  localparam int NUM_HID = 16;
  localparam int SETTLE_CYCLES = 48;
  localparam int NUM_PHASES = 7;
  localparam int PHASE_ITEMS = 38;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic signed [VAL_W-1:0] VAL_POS_MAX = 16'sh7fff;
  localparam logic signed [VAL_W-1:0] VAL_NEG_MAX = 16'sh8000;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic [UNIT_W-1:0]        row;
    logic [UNIT_W-1:0]        col;
    logic signed [VAL_W-1:0]  val;
    logic [VEC_W-1:0]         vbits;
    logic [VEC_W-1:0]         hbits;
  } query_item_t;

  typedef struct {
    logic signed [RES_W-1:0] value;
    logic [UNIT_W-1:0]       unit;
    logic                    last;
  } unit_result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          in_operation = '0;
  logic [UNIT_W-1:0]        in_row_index = '0;
  logic [UNIT_W-1:0]        in_column_index = '0;
  logic signed [VAL_W-1:0]  in_load_value = '0;
  logic [VEC_W-1:0]         in_visible_bits = '0;
  logic [VEC_W-1:0]         in_hidden_bits = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [RES_W-1:0]  out_result_value;
  logic [UNIT_W-1:0]        out_unit_index;
  logic                     out_last_result;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CNT_W-1:0]         cfg_data = '0;

  // predictor state
  logic signed [VAL_W-1:0] weight_mem [NUM_VIS][NUM_HID];
  logic signed [VAL_W-1:0] vbias_mem [NUM_VIS];
  logic signed [VAL_W-1:0] hbias_mem [NUM_HID];
  logic [CNT_W-1:0] vis_count = 5'd16;
  logic [CNT_W-1:0] hid_count = 5'd16;

  query_item_t  stim_q[$];
  unit_result_t expected_q[$];

  logic in_xfer = 1'b0;
  logic out_xfer = 1'b0;
  logic no_idle = 1'b0;
  int   in_gap = 0;
  int   out_wait = 0;
  int   fail_count = 0;

  rbm_energy_and_preactivation dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_row_index     (in_row_index),
    .in_column_index  (in_column_index),
    .in_load_value    (in_load_value),
    .in_visible_bits  (in_visible_bits),
    .in_hidden_bits   (in_hidden_bits),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_unit_index   (out_unit_index),
    .out_last_result  (out_last_result),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int active_units(input logic [CNT_W-1:0] cnt);
    if (cnt == 0) return 1;
    if (cnt > 16) return 16;
    return int'(cnt);
  endfunction

  function automatic logic signed [RES_W-1:0] clip_result(input longint acc);
    if (acc > rbme_pkg::RES_MAX) acc = rbme_pkg::RES_MAX;
    if (acc < rbme_pkg::RES_MIN) acc = rbme_pkg::RES_MIN;
    return acc[RES_W-1:0];
  endfunction

  // Updates the parameter stores or queues the results a query will produce.
  function automatic void predict_item(input query_item_t it);
    int nv;
    int nh;
    longint acc;
    unit_result_t r;
    nv = active_units(vis_count);
    nh = active_units(hid_count);
    case (it.op)
      rbme_pkg::OP_LOAD_W:  weight_mem[it.row][it.col] = it.val;
      rbme_pkg::OP_LOAD_VB: vbias_mem[it.row] = it.val;
      rbme_pkg::OP_LOAD_HB: hbias_mem[it.col] = it.val;
      rbme_pkg::OP_ENERGY: begin
        acc = 0;
        for (int i = 0; i < nv; i++)
          if (it.vbits[i]) acc += vbias_mem[i];
        for (int j = 0; j < nh; j++)
          if (it.hbits[j]) acc += hbias_mem[j];
        for (int i = 0; i < nv; i++)
          for (int j = 0; j < nh; j++)
            if (it.vbits[i] && it.hbits[j]) acc += weight_mem[i][j];
        r.value = clip_result(-acc);
        r.unit = '0;
        r.last = 1'b1;
        expected_q = {expected_q, r};
      end
      rbme_pkg::OP_HIDDEN: begin
        for (int j = 0; j < nh; j++) begin
          acc = hbias_mem[j];
          for (int i = 0; i < nv; i++)
            if (it.vbits[i]) acc += weight_mem[i][j];
          r.value = clip_result(acc);
          r.unit = UNIT_W'(j);
          r.last = (j + 1 == nh);
          expected_q = {expected_q, r};
        end
      end
      rbme_pkg::OP_VISIBLE: begin
        for (int i = 0; i < nv; i++) begin
          acc = vbias_mem[i];
          for (int j = 0; j < nh; j++)
            if (it.hbits[j]) acc += weight_mem[i][j];
          r.value = clip_result(acc);
          r.unit = UNIT_W'(i);
          r.last = (i + 1 == nv);
          expected_q = {expected_q, r};
        end
      end
      default: ;
    endcase
  endfunction

  function automatic query_item_t random_item();
    query_item_t it;
    int pick;
    pick = int'($urandom_range(0, 99));
    it.row = UNIT_W'($urandom_range(0, 15));
    it.col = UNIT_W'($urandom_range(0, 15));
    it.val = VAL_W'($urandom);
    it.vbits = VEC_W'($urandom);
    it.hbits = VEC_W'($urandom);
    if ($urandom_range(0, 4) == 0) it.val = $urandom_range(0, 1) ? VAL_POS_MAX : VAL_NEG_MAX;
    if ($urandom_range(0, 7) == 0) it.vbits = $urandom_range(0, 1) ? '1 : '0;
    if ($urandom_range(0, 7) == 0) it.hbits = $urandom_range(0, 1) ? '1 : '0;
    if (pick < 45)      it.op = rbme_pkg::OP_LOAD_W;
    else if (pick < 55) it.op = rbme_pkg::OP_LOAD_VB;
    else if (pick < 65) it.op = rbme_pkg::OP_LOAD_HB;
    else if (pick < 75) it.op = rbme_pkg::OP_ENERGY;
    else if (pick < 85) it.op = rbme_pkg::OP_HIDDEN;
    else if (pick < 95) it.op = rbme_pkg::OP_VISIBLE;
    else                it.op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
    return it;
  endfunction

  task automatic add_item(input logic [OP_W-1:0] op, input logic [UNIT_W-1:0] row,
                          input logic [UNIT_W-1:0] col, input logic signed [VAL_W-1:0] val,
                          input logic [VEC_W-1:0] vbits, input logic [VEC_W-1:0] hbits);
    query_item_t it;
    it.op = op;
    it.row = row;
    it.col = col;
    it.val = val;
    it.vbits = vbits;
    it.hbits = hbits;
    stim_q = {stim_q, it};
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == rbme_pkg::CFG_VISIBLE_COUNT) vis_count = data;
    else if (idx == rbme_pkg::CFG_HIDDEN_COUNT) hid_count = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sender drained and all results back, then room for a load still in flight.
  task automatic wait_idle();
    while (stim_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    query_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_xfer) begin
      // stalled transfer: hold payload
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap = in_gap - 1;
    end else if (stim_q.size() > 0) begin
      nxt = stim_q.pop_front();
      in_operation <= nxt.op;
      in_row_index <= nxt.row;
      in_column_index <= nxt.col;
      in_load_value <= nxt.val;
      in_visible_bits <= nxt.vbits;
      in_hidden_bits <= nxt.hbits;
      in_valid <= 1'b1;
      in_gap = no_idle ? 0 : int'($urandom_range(0, 11));
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result-side backpressure
  always @(negedge clk) begin
    if (out_xfer) out_wait = no_idle ? 0 : int'($urandom_range(0, 11));
    if (out_wait > 0) begin
      out_stall <= 1'b1;
      out_wait = out_wait - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: predict on input transfer, check on result transfer
  always @(posedge clk) begin
    query_item_t  seen;
    unit_result_t want;
    in_xfer <= rst_n && in_valid && !in_stall;
    out_xfer <= rst_n && out_valid && !out_stall;
    if (rst_n && in_valid && !in_stall) begin
      seen.op = in_operation;
      seen.row = in_row_index;
      seen.col = in_column_index;
      seen.val = in_load_value;
      seen.vbits = in_visible_bits;
      seen.hbits = in_hidden_bits;
      predict_item(seen);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: value %0d unit %0d last %0b",
               out_result_value, out_unit_index, out_last_result);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_result_value !== want.value) begin
          $error("result_value expected %0d actual %0d", want.value, out_result_value);
          fail_count++;
        end
        if (out_unit_index !== want.unit) begin
          $error("unit_index expected %0d actual %0d", want.unit, out_unit_index);
          fail_count++;
        end
        if (out_last_result !== want.last) begin
          $error("last_result expected %0d actual %0d", want.last, out_last_result);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic [CNT_W-1:0] vis_set [NUM_PHASES];
    logic [CNT_W-1:0] hid_set [NUM_PHASES];
    vis_set = '{5'd1, 5'd0, 5'd17, 5'd31, 5'd7, 5'd16, 5'd0};
    hid_set = '{5'd1, 5'd31, 5'd5, 5'd0, 5'd12, 5'd16, 5'd0};
    vis_set[NUM_PHASES-1] = CNT_W'($urandom_range(0, 31));
    hid_set[NUM_PHASES-1] = CNT_W'($urandom_range(0, 31));
    for (int i = 0; i < NUM_VIS; i++) begin
      vbias_mem[i] = '0;
      for (int j = 0; j < NUM_HID; j++) weight_mem[i][j] = '0;
    end
    for (int j = 0; j < NUM_HID; j++) hbias_mem[j] = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: cleared stores, corner weights and biases, every query, spare opcodes
    add_item(rbme_pkg::OP_ENERGY, 4'd0, 4'd0, 16'sd0, '1, '1);
    add_item(rbme_pkg::OP_LOAD_W, 4'd0, 4'd0, VAL_POS_MAX, VEC_W'($urandom), VEC_W'($urandom));
    add_item(rbme_pkg::OP_LOAD_W, 4'd15, 4'd15, VAL_NEG_MAX, VEC_W'($urandom),
             VEC_W'($urandom));
    add_item(rbme_pkg::OP_LOAD_W, 4'd0, 4'd15, VAL_NEG_MAX, VEC_W'($urandom), VEC_W'($urandom));
    add_item(rbme_pkg::OP_LOAD_W, 4'd15, 4'd0, VAL_POS_MAX, VEC_W'($urandom), VEC_W'($urandom));
    add_item(rbme_pkg::OP_LOAD_VB, 4'd0, 4'd7, VAL_POS_MAX, VEC_W'($urandom), VEC_W'($urandom));
    add_item(rbme_pkg::OP_LOAD_VB, 4'd15, 4'd3, VAL_NEG_MAX, VEC_W'($urandom),
             VEC_W'($urandom));
    add_item(rbme_pkg::OP_LOAD_HB, 4'd9, 4'd0, VAL_NEG_MAX, VEC_W'($urandom), VEC_W'($urandom));
    add_item(rbme_pkg::OP_LOAD_HB, 4'd2, 4'd15, VAL_POS_MAX, VEC_W'($urandom),
             VEC_W'($urandom));
    add_item(rbme_pkg::OP_ENERGY, 4'd15, 4'd15, 16'sd0, '1, '1);
    add_item(rbme_pkg::OP_ENERGY, 4'd0, 4'd0, -16'sd1, '0, '0);
    add_item(rbme_pkg::OP_ENERGY, 4'd5, 4'd10, 16'sd0, 16'h8001, 16'h8001);
    add_item(rbme_pkg::OP_HIDDEN, 4'd3, 4'd4, 16'sd0, '1, VEC_W'($urandom));
    add_item(rbme_pkg::OP_HIDDEN, 4'd0, 4'd0, 16'sd0, '0, VEC_W'($urandom));
    add_item(rbme_pkg::OP_VISIBLE, 4'd8, 4'd1, 16'sd0, VEC_W'($urandom), '1);
    add_item(rbme_pkg::OP_VISIBLE, 4'd0, 4'd0, 16'sd0, VEC_W'($urandom), 16'h8000);
    add_item(OP_SPARE_6, 4'd15, 4'd15, VAL_NEG_MAX, '1, '1);
    add_item(OP_SPARE_7, 4'd0, 4'd0, VAL_POS_MAX, '0, '0);
    add_item(rbme_pkg::OP_HIDDEN, 4'd0, 4'd0, 16'sd0, 16'h0001, '0);
    wait_idle();

    // unused register index must leave the counts alone
    write_reg(CFG_SPARE, 5'd3);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(rbme_pkg::CFG_VISIBLE_COUNT, vis_set[p]);
      write_reg(rbme_pkg::CFG_HIDDEN_COUNT, hid_set[p]);
      no_idle = (p == 2 || p == 5);
      for (int k = 0; k < PHASE_ITEMS; k++) stim_q = {stim_q, random_item()};
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("rbm_energy_and_preactivation: match");
    end else begin
      $display("rbm_energy_and_preactivation: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("rbm_energy_and_preactivation: mismatch");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/rbme_pkg.sv
rtl/core/rbme_ctrl.sv
rtl/core/rbme_datapath.sv
rtl/core/rbm_energy_and_preactivation.sv
test/tb.sv
